/* rtl/fetch_directed_instr_prefetcher_macros.svh */
// Assertion macros for the fetch-directed instruction prefetcher.
// Used by the port checker; needs clk and rst_n in scope.
`ifndef FETCH_DIRECTED_INSTR_PREFETCHER_MACROS_SVH
`define FETCH_DIRECTED_INSTR_PREFETCHER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FDIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define FDIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fdip_pkg.sv */
// Shared types, constants and helpers of the fetch-directed prefetcher.
// No dependencies.
package fdip_pkg;

    localparam int DEF_QUEUE_DEPTH  = 128;
    localparam int DEF_RECENT_DEPTH = 4;
    localparam int DEF_LOG2_LINE    = 6;
    localparam logic [7:0] MSHR_ENTRIES_RESET = 8'd8;

    // request kinds as they arrive on req_type
    typedef enum logic [1:0] {
        REQ_BRANCH = 2'd0,
        REQ_ACCESS = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } req_kind_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_DISP,
        B_SCAN,
        B_TICK,
        B_HEAD,
        B_FIN
    } back_state_t;

    // classified command word handed from front to back
    typedef struct packed {
        req_kind_t   kind;
        logic [63:0] target;    // raw address
        logic [63:0] line;      // branch line, or next line for an access
        logic        room;      // MSHR under half full
        logic        miss;
        logic        head_hit;
        logic [31:0] meta;
    } cmd_t;

    function automatic logic [63:0] line_of(input logic [63:0] a, input int lg);
        line_of = a & ~((64'd1 << lg) - 64'd1);
    endfunction

endpackage

/* rtl/fdip_front.sv */
// Front end: config register, request classification and a two-word command queue.
// Depends on fdip_pkg.
module fdip_front #(
    parameter int LOG2_LINE = fdip_pkg::DEF_LOG2_LINE
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       mshr_entries,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [1:0]       req_type,
    input  logic [63:0]      addr,
    input  logic             access_hit,
    input  logic [7:0]       mshr_occupancy,
    input  logic             head_in_cache,
    input  logic [31:0]      metadata,
    output logic             cmd_valid,
    output fdip_pkg::cmd_t   cmd,
    input  logic             cmd_pop
);
    import fdip_pkg::*;

    logic [7:0] mshr_entries_reg;
    cmd_t       fifo_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       cls;
    logic       push;

    assign cfg_ready = 1'b1;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mshr_entries_reg <= MSHR_ENTRIES_RESET;
        end
        else if (cfg_valid)
        begin
            mshr_entries_reg <= mshr_entries;
        end
    end

    // classify the incoming request
    always_comb
    begin
        cls.kind     = req_kind_t'(req_type);
        cls.target   = addr;
        cls.line     = (req_type == REQ_ACCESS)
                     ? line_of(addr, LOG2_LINE) + (64'd1 << LOG2_LINE)
                     : line_of(addr, LOG2_LINE);
        cls.room     = mshr_occupancy < {1'b0, mshr_entries_reg[7:1]};
        cls.miss     = !access_hit;
        cls.head_hit = head_in_cache;
        cls.meta     = metadata;
    end

    assign req_stall = cnt_reg[1];
    assign push      = req_valid && !req_stall;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = fifo_reg[rptr_reg];

    // command queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (cmd_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(cmd_pop);
        end
    end

    // command queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= cls;
        end
    end

endmodule

/* rtl/fdip_back.sv */
// Back end: prefetch queue memory, recent-line list, sequencer and result register.
// Depends on fdip_pkg.
module fdip_back #(
    parameter int QUEUE_DEPTH  = fdip_pkg::DEF_QUEUE_DEPTH,
    parameter int RECENT_DEPTH = fdip_pkg::DEF_RECENT_DEPTH,
    parameter int LOG2_LINE    = fdip_pkg::DEF_LOG2_LINE
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  fdip_pkg::cmd_t   cmd,
    output logic             cmd_pop,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic             pf_valid,
    output logic [63:0]      pf_line_addr,
    output logic [31:0]      pf_metadata,
    output logic             head_valid,
    output logic [63:0]      head_target,
    output logic [7:0]       queue_count
);
    import fdip_pkg::*;

    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int RHW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
    localparam int RFW = $clog2(RECENT_DEPTH + 1);

    back_state_t    state_reg, state_next;
    cmd_t           cur_reg;
    logic [63:0]    mem [QUEUE_DEPTH];
    logic [63:0]    rd_data_reg;
    logic [QW-1:0]  rd_addr;
    logic [QW-1:0]  head_reg;
    logic [CW-1:0]  fill_reg, iss_reg;
    logic           cmp_v_reg;
    logic [63:0]    recent_reg [RECENT_DEPTH];
    logic [RHW-1:0] rhead_reg;
    logic [RFW-1:0] rfill_reg;
    logic           pv_reg;
    logic [63:0]    pa_reg;
    logic [31:0]    pm_reg;
    logic           rsp_valid_reg, out_pv_reg, out_hv_reg;
    logic [63:0]    out_pa_reg, out_ht_reg;
    logic [31:0]    out_pm_reg;
    logic [7:0]     out_qc_reg;

    logic [63:0]    blk_chk, rd_line, rec_in;
    logic           rec_hit, match, found, push_now, issue, rec_push, load;

    // ring slot of offset o from head h
    function automatic logic [QW-1:0] slot(input logic [QW-1:0] h, input logic [CW-1:0] o);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(o);
        if (s >= (CW+1)'(QUEUE_DEPTH))
        begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        slot = s[QW-1:0];
    endfunction

    function automatic logic [QW-1:0] inc_ptr(input logic [QW-1:0] p);
        inc_ptr = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
    endfunction

    // decision terms
    assign rd_line  = line_of(rd_data_reg, LOG2_LINE);
    assign blk_chk  = (state_reg == B_TICK) ? rd_line : cur_reg.line;
    assign match    = cmp_v_reg && (rd_line == cur_reg.line);
    assign found    = (state_reg == B_SCAN) && match;
    assign push_now = (state_reg == B_SCAN) && !match && !cmp_v_reg && (iss_reg == fill_reg);
    assign issue    = (state_reg == B_TICK) && !cur_reg.head_hit && !rec_hit;
    assign rec_push = issue || ((state_reg == B_DISP) && (cur_reg.kind == REQ_ACCESS)
                                && cur_reg.miss && cur_reg.room);
    assign rec_in   = (state_reg == B_TICK) ? rd_line : cur_reg.line;
    assign load     = (state_reg == B_FIN) && (!rsp_valid_reg || !rsp_stall);
    assign cmd_pop  = (state_reg == B_IDLE) && cmd_valid;
    assign rd_addr  = (state_reg == B_SCAN) ? slot(head_reg, iss_reg) : head_reg;

    // recent-line lookup; slots fill from zero before the head moves
    always_comb
    begin
        rec_hit = 1'b0;
        for (int j = 0; j < RECENT_DEPTH; j++)
        begin
            if (RFW'(j) < rfill_reg && recent_reg[j] == blk_chk)
            begin
                rec_hit = 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (cmd_valid) state_next = B_DISP;
            B_DISP:
            begin
                case (cur_reg.kind)
                    REQ_BRANCH: state_next = (cur_reg.line != 64'd0 && !rec_hit)
                                           ? B_SCAN : B_HEAD;
                    REQ_TICK:   state_next = (fill_reg != '0 && cur_reg.room)
                                           ? B_TICK : B_HEAD;
                    default:    state_next = B_HEAD;
                endcase
            end
            B_SCAN: if (found || push_now) state_next = B_HEAD;
            B_TICK: state_next = B_HEAD;
            B_HEAD: state_next = B_FIN;
            B_FIN:  if (load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            iss_reg       <= '0;
            cmp_v_reg     <= 1'b0;
            rhead_reg     <= '0;
            rfill_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // scan issue counter and compare-valid pipe
            if (state_reg == B_DISP)
            begin
                iss_reg   <= '0;
                cmp_v_reg <= 1'b0;
            end
            else if (state_reg == B_SCAN)
            begin
                cmp_v_reg <= iss_reg < fill_reg;
                if (iss_reg < fill_reg)
                begin
                    iss_reg <= iss_reg + CW'(1);
                end
            end
            // queue pointer updates
            if (push_now)
            begin
                if (fill_reg == CW'(QUEUE_DEPTH))
                begin
                    head_reg <= inc_ptr(head_reg);
                end
                else
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end
            else if (state_reg == B_TICK)
            begin
                head_reg <= inc_ptr(head_reg);
                fill_reg <= fill_reg - CW'(1);
            end
            // recent list pointers
            if (rec_push && rfill_reg == RFW'(RECENT_DEPTH))
            begin
                rhead_reg <= (rhead_reg == RHW'(RECENT_DEPTH - 1)) ? '0 : rhead_reg + RHW'(1);
            end
            else if (rec_push)
            begin
                rfill_reg <= rfill_reg + RFW'(1);
            end
            // result register valid
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        if (state_reg == B_DISP)
        begin
            pv_reg <= 1'b0;
            pa_reg <= '0;
            pm_reg <= '0;
            if (cur_reg.kind == REQ_ACCESS && cur_reg.miss && cur_reg.room)
            begin
                pv_reg <= 1'b1;
                pa_reg <= cur_reg.line;
                pm_reg <= cur_reg.meta;
            end
        end
        else if (issue)
        begin
            pv_reg <= 1'b1;
            pa_reg <= rd_line;
            pm_reg <= '0;
        end
        if (rec_push)
        begin
            if (rfill_reg == RFW'(RECENT_DEPTH))
            begin
                recent_reg[rhead_reg] <= rec_in;
            end
            else
            begin
                recent_reg[rfill_reg[RHW-1:0]] <= rec_in;
            end
        end
        if (load)
        begin
            out_pv_reg <= pv_reg;
            out_pa_reg <= pa_reg;
            out_pm_reg <= pm_reg;
            out_hv_reg <= fill_reg != '0;
            out_ht_reg <= (fill_reg != '0) ? rd_data_reg : 64'd0;
            out_qc_reg <= 8'(fill_reg);
        end
    end

    // prefetch queue memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (push_now)
        begin
            mem[slot(head_reg, fill_reg)] <= cur_reg.target;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp_valid    = rsp_valid_reg;
    assign pf_valid     = out_pv_reg;
    assign pf_line_addr = out_pa_reg;
    assign pf_metadata  = out_pm_reg;
    assign head_valid   = out_hv_reg;
    assign head_target  = out_ht_reg;
    assign queue_count  = out_qc_reg;

endmodule

/* rtl/fetch_directed_instr_prefetcher.sv */
// Top level of the fetch-directed instruction prefetcher.
// Depends on fdip_pkg, fdip_front and fdip_back.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, mshr_entries) writes the MSHR size;
//    ready is always high. Write only while the block is idle.
//  - req channel (req_valid/req_stall) takes one branch event, cache access
//    or tick per word into a two-word command queue.
//  - rsp channel (rsp_valid/rsp_stall) returns exactly one result word per
//    request, in order, from an output register.
// Timing: from acceptance to rsp_valid a cache access, an unknown request or
// a branch that needs no search passes pop, decode, head read and result
// load; a tick with a non-empty queue and MSHR room adds a queue-pop step.
// A branch checked for duplicates walks the queue memory one entry per cycle
// through its single read port. Requests are served one at a time.
// Reset: queue and recent list empty, mshr_entries = 8; memory contents are
// not cleared, since only values from live entries are ever used.
// When rsp_stall is high the result holds; the back end finishes the next
// request and waits, and the front accepts up to two more words.
module fetch_directed_instr_prefetcher #(
    parameter int QUEUE_DEPTH  = fdip_pkg::DEF_QUEUE_DEPTH,
    parameter int RECENT_DEPTH = fdip_pkg::DEF_RECENT_DEPTH,
    parameter int LOG2_LINE    = fdip_pkg::DEF_LOG2_LINE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  mshr_entries,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [63:0] addr,
    input  logic        access_hit,
    input  logic [7:0]  mshr_occupancy,
    input  logic        head_in_cache,
    input  logic [31:0] metadata,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        pf_valid,
    output logic [63:0] pf_line_addr,
    output logic [31:0] pf_metadata,
    output logic        head_valid,
    output logic [63:0] head_target,
    output logic [7:0]  queue_count
);
    import fdip_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_pop;

    fdip_front #(.LOG2_LINE(LOG2_LINE)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .mshr_entries   (mshr_entries),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .addr           (addr),
        .access_hit     (access_hit),
        .mshr_occupancy (mshr_occupancy),
        .head_in_cache  (head_in_cache),
        .metadata       (metadata),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop)
    );

    fdip_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .RECENT_DEPTH (RECENT_DEPTH),
        .LOG2_LINE    (LOG2_LINE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .pf_valid     (pf_valid),
        .pf_line_addr (pf_line_addr),
        .pf_metadata  (pf_metadata),
        .head_valid   (head_valid),
        .head_target  (head_target),
        .queue_count  (queue_count)
    );

endmodule

/* rtl/fdip_checker.sv */
// Port-level checker for the fetch-directed prefetcher, bound to the top level.
// Depends on fetch_directed_instr_prefetcher_macros.svh.
`include "fetch_directed_instr_prefetcher_macros.svh"

module fdip_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic        pf_valid,
    input logic [63:0] pf_line_addr,
    input logic [31:0] pf_metadata,
    input logic        head_valid,
    input logic [63:0] head_target,
    input logic [7:0]  queue_count
);

    // a stalled result stays valid and keeps its prefetch address
    `FDIP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(pf_line_addr), "stalled result changed")

    // no address or metadata without a prefetch
    `FDIP_ASSERT_NOW(a_pf_zero, rsp_valid && !pf_valid, pf_line_addr == 64'd0 && pf_metadata == 32'd0, "idle prefetch fields not zero")

    // empty queue reports no count
    `FDIP_ASSERT_NOW(a_empty_count, rsp_valid && !head_valid, queue_count == 8'd0, "empty queue with nonzero count")

    // empty queue reports no head target
    `FDIP_ASSERT_NOW(a_empty_target, rsp_valid && !head_valid, head_target == 64'd0, "empty queue with head target")

endmodule

bind fetch_directed_instr_prefetcher fdip_checker u_fdip_checker (.*);
